// ----- hdl/idd_pkg.sv -----
package idd_pkg;

   localparam int COORD_BITS  = 16;
   localparam int FACTOR_BITS = 8;

   // Register widths fixed by the register map.
   localparam int FACTOR_REG_BITS = 8;
   localparam int SIZE_REG_BITS   = 16;
   localparam int BPP_REG_BITS    = 3;

   // Comparison widths wide enough for both the counter and its register.
   localparam int COORD_CMP_BITS = (COORD_BITS > SIZE_REG_BITS) ? COORD_BITS : SIZE_REG_BITS;
   localparam int PHASE_CMP_BITS =
      (FACTOR_BITS > FACTOR_REG_BITS) ? FACTOR_BITS : FACTOR_REG_BITS;

   localparam int PIXEL_BITS  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Register indexes.
   localparam logic [1:0] REG_SCALE_FACTOR    = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd2;
   localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd3;

   typedef struct packed {
      logic [FACTOR_REG_BITS-1:0] scale_factor;
      logic [SIZE_REG_BITS-1:0]   image_width;
      logic [SIZE_REG_BITS-1:0]   image_height;
      logic [BPP_REG_BITS-1:0]    bytes_per_pixel;
   } cfg_type;

   // One kept pixel as handed from the front end to the byte serializer.
   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic [1:0]            bytes_m1;   // pixel bytes minus one
      logic [1:0]            pad_bytes;  // zero bytes appended after the pixel
      logic                  row_end;    // pixel closes an output row
   } qent_type;

endpackage

// ----- hdl/idd_front.sv -----
module idd_front import idd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     pix_valid,
   input  logic [PIXEL_BITS-1:0] pix_data,
   input  logic     q_full,
   output logic     pix_ready,
   output logic     q_push,
   output qent_type q_data
);

   logic [COORD_BITS-1:0]  column_count_ff, column_count_in;
   logic [COORD_BITS-1:0]  row_count_ff, row_count_in;
   logic [FACTOR_BITS-1:0] column_phase_ff, column_phase_in;
   logic [FACTOR_BITS-1:0] row_phase_ff, row_phase_in;
   logic [1:0]             out_byte_phase_ff, out_byte_phase_in;

   logic [FACTOR_REG_BITS-1:0] f_eff;
   logic [SIZE_REG_BITS-1:0]   w_eff, h_eff;
   logic [1:0]                 d_m1;
   logic                       last_col, last_row, col_blk_end, row_blk_end, keep;
   logic                       accept;
   logic [1:0]                 phase_sum;

   assign pix_ready = !q_full;
   assign accept    = pix_valid && pix_ready;

   always_comb begin
      f_eff = (cfg.scale_factor == '0) ? FACTOR_REG_BITS'(1) : cfg.scale_factor;
      w_eff = (cfg.image_width  == '0) ? SIZE_REG_BITS'(1) : cfg.image_width;
      h_eff = (cfg.image_height == '0) ? SIZE_REG_BITS'(1) : cfg.image_height;
      unique case (cfg.bytes_per_pixel)
         3'd0, 3'd1: d_m1 = 2'd0;
         3'd2:       d_m1 = 2'd1;
         3'd3:       d_m1 = 2'd2;
         default:    d_m1 = 2'd3;
      endcase

      last_col    = COORD_CMP_BITS'(column_count_ff) >= COORD_CMP_BITS'(w_eff - 1'b1);
      last_row    = COORD_CMP_BITS'(row_count_ff) >= COORD_CMP_BITS'(h_eff - 1'b1);
      col_blk_end = PHASE_CMP_BITS'(column_phase_ff) >= PHASE_CMP_BITS'(f_eff - 1'b1);
      row_blk_end = PHASE_CMP_BITS'(row_phase_ff) >= PHASE_CMP_BITS'(f_eff - 1'b1);
      keep        = (col_blk_end || last_col) && (row_blk_end || last_row);

      phase_sum = out_byte_phase_ff + d_m1 + 2'd1;

      q_data.pixel     = pix_data;
      q_data.bytes_m1  = d_m1;
      q_data.pad_bytes = last_col ? 2'(2'd0 - phase_sum) : 2'd0;
      q_data.row_end   = last_col;
      q_push           = accept && keep;

      column_count_in   = column_count_ff;
      row_count_in      = row_count_ff;
      column_phase_in   = column_phase_ff;
      row_phase_in      = row_phase_ff;
      out_byte_phase_in = out_byte_phase_ff;
      if (accept) begin
         if (keep) begin
            out_byte_phase_in = phase_sum;
         end
         if (last_col) begin
            column_count_in   = '0;
            column_phase_in   = '0;
            out_byte_phase_in = '0;
            if (last_row) begin
               row_count_in = '0;
               row_phase_in = '0;
            end else begin
               row_count_in = row_count_ff + 1'b1;
               row_phase_in = row_blk_end ? '0 : row_phase_ff + 1'b1;
            end
         end else begin
            column_count_in = column_count_ff + 1'b1;
            column_phase_in = col_blk_end ? '0 : column_phase_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff   <= '0;
         row_count_ff      <= '0;
         column_phase_ff   <= '0;
         row_phase_ff      <= '0;
         out_byte_phase_ff <= '0;
      end else begin
         column_count_ff   <= column_count_in;
         row_count_ff      <= row_count_in;
         column_phase_ff   <= column_phase_in;
         row_phase_ff      <= row_phase_in;
         out_byte_phase_ff <= out_byte_phase_in;
      end
   end

endmodule

// ----- hdl/idd_queue.sv -----
module idd_queue import idd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  qent_type push_data,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output qent_type head
);

   qent_type                  slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   assign full      = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   function automatic logic [QUEUE_PTR_BITS-1:0] ptr_next(input logic [QUEUE_PTR_BITS-1:0] p);
      ptr_next = (p == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/idd_back.sv -----
module idd_back import idd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_not_empty,
   input  qent_type   q_head,
   output logic       q_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       out_padding,
   output logic       out_row_done,
   output logic       out_last
);

   qent_type   cur_ff, cur_in, sel;
   logic [2:0] idx_ff, idx_in, sel_idx, total;
   logic       busy_ff, busy_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       pad_ff, pad_in, done_ff, done_in, last_ff, last_in;
   logic       advance, have, fin, is_pix;

   assign advance = !valid_ff || out_ready;

   always_comb begin
      sel     = busy_ff ? cur_ff : q_head;
      sel_idx = busy_ff ? idx_ff : 3'd0;
      have    = busy_ff || q_not_empty;
      q_pop   = advance && !busy_ff && q_not_empty;

      total  = 3'(sel.bytes_m1) + 3'd1 + 3'(sel.pad_bytes);
      fin    = (sel_idx + 3'd1 == total);
      is_pix = (sel_idx <= 3'(sel.bytes_m1));

      valid_in = valid_ff;
      byte_in  = byte_ff;
      pad_in   = pad_ff;
      done_in  = done_ff;
      last_in  = last_ff;
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      cur_in   = cur_ff;
      if (advance) begin
         valid_in = have;
         byte_in  = is_pix ? sel.pixel[{sel_idx[1:0], 3'b000} +: 8] : 8'd0;
         pad_in   = !is_pix;
         done_in  = sel.row_end && fin;
         last_in  = fin;
         busy_in  = have && !fin;
         idx_in   = sel_idx + 3'd1;
         cur_in   = sel;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      pad_ff  <= pad_in;
      done_ff <= done_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
      cur_ff  <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         busy_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         busy_ff  <= busy_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_byte     = byte_ff;
   assign out_padding  = pad_ff;
   assign out_row_done = done_ff;
   assign out_last     = last_ff;

endmodule

// ----- hdl/image_downscale_decimator_unit.sv -----
// Image downscaler by decimation. Source pixels arrive one per transfer on the req_ stream in
// raster order, without source row padding, each pixel in the low bytes of req_tdata with the
// first file byte in bits 7:0. A pixel is kept when it is the last column of an f-wide block
// (or the last image column) and lies in the last row of an f-high block (or the last image
// row); kept pixels leave on the rsp_ stream one byte per transfer, low byte first, and after
// the last pixel of every kept row zero bytes are added so the output row is a multiple of four
// bytes. The front end takes one pixel per clock as long as its two-entry queue has room;
// a dropped pixel is taken like any other but produces nothing. The byte-wide output
// register sets the rate: a kept pixel passes through it as bytes_per_pixel bytes (1 to 4),
// and a pixel that ends a row as up to three more bytes of padding.
// The rsp_ side may stall freely; the front keeps counting until the queue fills.
// Registers at byte addresses 0, 4, 8 and 12: scale_factor, image_width, image_height,
// bytes_per_pixel (resets 1, 1, 1, 3). A zero factor, width or height acts as one, and
// bytes_per_pixel is clamped to 1..4. Writes take effect at once and do not clear the
// counters, so they belong between frames while the block is idle.
module image_downscale_decimator_unit import idd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Pixel input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] pixel_value
   // Byte output stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_byte
   output logic [1:0]  rsp_tuser,    // [0] is_padding, [1] row_done
   output logic        rsp_tlast,    // last transfer caused by one input pixel
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type  cfg_ff, cfg_in;
   logic     cfg_write;
   logic     q_push, q_pop, q_full, q_not_empty;
   qent_type q_data, q_head;

   // Register file. The write strobe follows the access phase of the bus.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (csr_paddr[3:2])
            REG_SCALE_FACTOR:    cfg_in.scale_factor    = csr_pwdata[FACTOR_REG_BITS-1:0];
            REG_IMAGE_WIDTH:     cfg_in.image_width     = csr_pwdata[SIZE_REG_BITS-1:0];
            REG_IMAGE_HEIGHT:    cfg_in.image_height    = csr_pwdata[SIZE_REG_BITS-1:0];
            REG_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_pwdata[BPP_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SCALE_FACTOR:    csr_prdata = 32'(cfg_ff.scale_factor);
         REG_IMAGE_WIDTH:     csr_prdata = 32'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT:    csr_prdata = 32'(cfg_ff.image_height);
         REG_BYTES_PER_PIXEL: csr_prdata = 32'(cfg_ff.bytes_per_pixel);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_factor    <= FACTOR_REG_BITS'(1);
         cfg_ff.image_width     <= SIZE_REG_BITS'(1);
         cfg_ff.image_height    <= SIZE_REG_BITS'(1);
         cfg_ff.bytes_per_pixel <= BPP_REG_BITS'(3);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end tracks raster position and decides which pixels survive.
   idd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pix_valid (req_tvalid),
      .pix_data  (req_tdata),
      .q_full    (q_full),
      .pix_ready (req_tready),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   // Kept pixels wait here so that input and output can stall independently.
   idd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // The back end turns each kept pixel into byte transfers plus row padding.
   idd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_not_empty  (q_not_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_byte     (rsp_tdata),
      .out_padding  (rsp_tuser[0]),
      .out_row_done (rsp_tuser[1]),
      .out_last     (rsp_tlast)
   );

endmodule

// ----- hdl/idd_checker.sv -----
module idd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // A stalled byte transfer holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp transfer changed while stalled");

   // Padding bytes are always zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 8'd0)
      else $error("padding byte is not zero");

   // The end of an output row is also the end of the bytes of one pixel.
   a_row_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("row end without pixel end");

   // A padding byte that does not close the row is followed by more padding.
   a_pad_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser[0] && !rsp_tlast
         |=> !rsp_tvalid || rsp_tuser[0])
      else $error("padding run broken");

   // Nothing is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

bind image_downscale_decimator_unit idd_checker u_idd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
